// ----- src/ple_pkg.sv -----
// Package for the positional list engine: beat structs, action and status codes,
// and the per-cell control bundle. Used by every module under src.
// No dependencies.
package ple_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned STAT_W    = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_AT    = 3'd1,
    ACT_LIST      = 3'd2,
    ACT_WRITE_AT  = 3'd3,
    ACT_DELETE_AT = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] item_value;
    logic [POS_W-1:0]         item_index;
    logic [POS_W-1:0]         item_count;
    logic                     last;
  } out_item_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [POS_W-1:0]         slot;
    logic [POS_W-1:0]         tail;
    logic signed [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

// ----- src/ple_cell.sv -----
// One storage cell of the list chain: holds one word and trades it with its
// neighbors under the shared control bundle. Depends on ple_pkg.
module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                              clk,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic signed [ple_pkg::WORD_W-1:0] left_i,
  input  logic signed [ple_pkg::WORD_W-1:0] right_i,
  input  logic signed [ple_pkg::WORD_W-1:0] head_i,
  output logic signed [ple_pkg::WORD_W-1:0] data_o
);

  localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(IDX);

  logic signed [ple_pkg::WORD_W-1:0] data_r;
  logic signed [ple_pkg::WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      ple_pkg::OP_INSERT: begin
        if (MY_IDX > ctl.slot) begin
          data_nxt = left_i;
        end else if (MY_IDX == ctl.slot) begin
          data_nxt = ctl.word;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (MY_IDX >= ctl.slot) begin
          data_nxt = right_i;
        end
      end
      ple_pkg::OP_WRITE: begin
        if (MY_IDX == ctl.slot) begin
          data_nxt = ctl.word;
        end
      end
      ple_pkg::OP_ROTATE: begin
        // wrap the head to the tail so the list is whole again after one pass
        if (MY_IDX == ctl.tail) begin
          data_nxt = head_i;
        end else if (MY_IDX < ctl.tail) begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- src/positional_list_engine.sv -----
// Top level of the positional list engine: sequencer, count and output
// register around a chain of ple_cell. Depends on ple_pkg and ple_cell.
//
// Use: one input beat on in_valid/in_ready carries an action, a value and a
// one-based position. Results leave on out_valid/out_ready, one beat each,
// with last set on the final beat caused by an input.
// A valid insert, overwrite or delete updates the cell chain at the accepting edge;
// these, clear and unused codes present one status beat in the next cycle, so
// such actions run at one item per cycle while the receiver keeps up.
// List rotates the chain by one cell per cycle while the receiver keeps up and
// streams the head cell, N beats for N elements, from the list state entered
// at acceptance; no new item is taken until the last beat is registered.
// An empty list answers with one beat of status empty.
// Reset (rst_n low at a clock edge) empties the list and drops any pending
// beat; cell contents are not cleared, only the count.
// A stalled receiver holds the output register; the chain then holds too
// and input is not accepted until the beat is taken.
module positional_list_engine #(
  parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ple_pkg::out_item_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ple_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      k_inc;
  logic               out_valid_r, out_valid_nxt;
  ple_pkg::out_item_t out_r, out_nxt;
  ple_pkg::cell_ctl_t ctl;
  logic               in_fire, out_free, full;
  logic [PW:0]        pos_w, cnt_w;
  logic signed [ple_pkg::WORD_W-1:0] cell_q [DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign full     = (cnt_r == CW'(DEPTH));
  assign pos_w    = {1'b0, in_data.position};
  assign cnt_w    = (PW + 1)'(cnt_r);
  assign k_inc    = k_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ctl.op        = ple_pkg::OP_HOLD;
    ctl.slot      = in_data.position - 1'b1;
    ctl.tail      = PW'(cnt_r) - 1'b1;
    ctl.word      = in_data.value;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_nxt.status     = ple_pkg::STAT_OK;
          out_nxt.item_value = '0;
          out_nxt.item_index = '0;
          out_nxt.last       = 1'b1;
          out_valid_nxt      = 1'b1;
          case (in_data.action)
            ple_pkg::ACT_INS_FRONT: begin
              if (full) begin
                out_nxt.status = ple_pkg::STAT_FULL;
              end else begin
                ctl.op   = ple_pkg::OP_INSERT;
                ctl.slot = '0;
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            ple_pkg::ACT_INS_AT: begin
              if (full) begin
                out_nxt.status = ple_pkg::STAT_FULL;
              end else if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
                out_nxt.status = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op  = ple_pkg::OP_INSERT;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ple_pkg::ACT_LIST: begin
              if (cnt_r == '0) begin
                out_nxt.status = ple_pkg::STAT_EMPTY;
              end else begin
                // hold the beat back; the list state streams the elements
                out_valid_nxt = 1'b0;
                k_nxt         = '0;
                state_nxt     = S_LIST;
              end
            end
            ple_pkg::ACT_WRITE_AT: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                out_nxt.status = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op = ple_pkg::OP_WRITE;
              end
            end
            ple_pkg::ACT_DELETE_AT: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                out_nxt.status = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op  = ple_pkg::OP_DELETE;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            ple_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: ;
          endcase
          out_nxt.item_count = PW'(cnt_nxt);
        end
      end
      S_LIST: begin
        if (out_free) begin
          ctl.op             = ple_pkg::OP_ROTATE;
          out_valid_nxt      = 1'b1;
          out_nxt.status     = ple_pkg::STAT_OK;
          out_nxt.item_value = cell_q[0];
          out_nxt.item_index = PW'(k_inc);
          out_nxt.item_count = PW'(cnt_r);
          out_nxt.last       = (k_inc == cnt_r);
          k_nxt              = k_inc;
          if (k_inc == cnt_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [ple_pkg::WORD_W-1:0] left_d, right_d;
      if (gi == 0) begin : g_first
        assign left_d = cell_q[0];
      end else begin : g_mid_l
        assign left_d = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cell_q[DEPTH-1];
      end else begin : g_mid_r
        assign right_d = cell_q[gi+1];
      end
      ple_cell #(.IDX(gi)) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .left_i  (left_d),
        .right_i (right_d),
        .head_i  (cell_q[0]),
        .data_o  (cell_q[gi])
      );
    end
  endgenerate

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/ple_checker.sv -----
// Port-level checker for positional_list_engine, attached by bind below.
// Depends on ple_pkg and the top level's port list.
module ple_checker #(
  parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ple_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ple_pkg::out_item_t out_data
);

  localparam logic [ple_pkg::POS_W-1:0] DEPTH_P = ple_pkg::POS_W'(DEPTH);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset drops any pending beat
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.item_count <= DEPTH_P)
    else $error("count beyond depth");

  // only listed elements may be non-final beats, and they carry an index
  a_stream_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.status == ple_pkg::STAT_OK && out_data.item_index != '0 &&
      out_data.item_index < out_data.item_count)
    else $error("bad non-final result beat");

  // no input is taken while a list stream is in flight
  a_no_in_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input accepted during a list stream");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);
